// File: design/ath_pkg.sv
// Package for the allocation tracking hash table.
// Holds field widths, status codes, request/result structs and the hash table function.
// No dependencies.
package ath_pkg;

  localparam int DEPTH_DEFAULT    = 1024;
  localparam int KEY_BITS_DEFAULT = 32;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 32;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 10;

  localparam logic [31:0] HASH_POLY = 32'hEDB88320;
  localparam logic [31:0] HASH_FLIP = 32'hFF000000;

  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] alloc_size;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [SIZE_W-1:0] released_size;
    logic [CNT_W-1:0]  outstanding_count;
    logic [CNT_W-1:0]  bytes_in_use;
    logic [CNT_W-1:0]  peak_count;
    logic [CNT_W-1:0]  peak_bytes;
  } result_t;

  function automatic logic [31:0] hash_entry(input logic [7:0] b);
    logic [31:0] v;
    v = {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v[0] ? 32'h0 : HASH_POLY) ^ (v >> 1);
    end
    return v ^ HASH_FLIP;
  endfunction

endpackage

// File: design/ath_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the slot key and slot size stores. No dependencies.
module ath_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/allocation_tracking_hash_table.sv
// Allocation tracking hash table, top level.
// Depends on ath_pkg and ath_ram (slot key and slot size stores).
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and busy low.
//   A record item stores address and size in the first empty slot found by linear
//   probing from the hashed home slot; a release item finds the address and clears it.
//   Result: done is high for exactly one cycle with result valid; the receiver
//   cannot stall it, so the result must be taken in that cycle.
//   Config channel: cfg_valid/cfg_ready (always ready) writes tracking_enable; write
//   it only while the block is idle.
//   Sequence: an ignored item returns its result in the cycle after transfer. A tracked
//   item is hashed (one table lookup per address byte), reduced modulo TABLE_DEPTH
//   when TABLE_DEPTH is not a power of two, and probed with one key store read per
//   probed slot plus a registered read; a found slot is then written back and done
//   is raised. busy is low again while done is high, so a new item can transfer
//   while the last result is shown; a full scan costs TABLE_DEPTH probes.
//   Reset: synchronous rst clears counters and tracking_enable, then a clearing pass
//   writes every key slot to empty with busy held high.
module allocation_tracking_hash_table #(
  parameter int TABLE_DEPTH = ath_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS    = ath_pkg::KEY_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ath_pkg::request_t request,
  output logic              done,
  output ath_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  import ath_pkg::*;

  localparam int  AW       = $clog2(TABLE_DEPTH);
  localparam int  RW       = AW + 1;
  localparam int  CW       = AW + 1;
  localparam int  KEY_W    = (KEY_BITS < ADDR_W) ? KEY_BITS : ADDR_W;
  localparam bit  DEPTH_P2 = ((1 << AW) == TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t            state;
  logic              en;
  logic              op;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] size;
  logic [31:0]       h;
  logic [1:0]        hcnt;
  logic [31:0]       q;
  logic [RW-1:0]     r;
  logic [2:0]        mcnt;
  logic [AW-1:0]     rd_idx;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic [CW-1:0]     checked;
  logic              hit;
  logic [AW-1:0]     slot;
  logic [SIZE_W-1:0] rel;
  logic [AW-1:0]     clr_idx;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  live_bytes;
  logic [CNT_W-1:0]  max_count;
  logic [CNT_W-1:0]  max_bytes;

  logic [31:0]       key32;
  logic [31:0]       h_next;
  logic [RW-1:0]     r_next;
  logic [31:0]       q_next;
  logic [AW-1:0]     rd_idx_next;
  logic [KEY_W-1:0]  rd_key;
  logic [SIZE_W-1:0] rd_bytes;
  logic              match;
  logic              key_we;
  logic [AW-1:0]     key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic              bytes_we;
  logic              ignore;
  logic [KEY_W-1:0]  req_key;
  logic [CNT_W:0]    bytes_sum;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  bytes_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  bytes_dec;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign req_key = request.address[KEY_W-1:0];
  assign ignore  = !en || (req_key == '0) ||
                   (request.operation == OP_RECORD && request.alloc_size == '0);

  assign key32  = 32'(key);
  assign h_next = hash_entry(h[7:0] ^ key32[hcnt*8 +: 8]) ^ (h >> 8);

  always_comb begin
    r_next = r;
    q_next = q;
    for (int s = 0; s < 4; s++) begin
      r_next = {r_next[RW-2:0], q_next[31]};
      q_next = q_next << 1;
      if (r_next >= RW'(TABLE_DEPTH)) begin
        r_next = r_next - RW'(TABLE_DEPTH);
      end
    end
  end

  assign rd_idx_next = (rd_idx == AW'(TABLE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
  assign match       = (op == OP_RECORD) ? (rd_key == '0) : (rd_key == key);

  assign key_we    = (state == S_CLEAR) || (state == S_FINISH && hit);
  assign key_waddr = (state == S_CLEAR) ? clr_idx : slot;
  assign key_wdata = (state == S_CLEAR || op == OP_RELEASE) ? '0 : key;
  assign bytes_we  = (state == S_FINISH) && hit && (op == OP_RECORD);

  assign bytes_sum = {1'b0, live_bytes} + {1'b0, size};
  assign cnt_inc   = (live_count == CNT_MAX) ? CNT_MAX : live_count + 1'b1;
  assign bytes_inc = bytes_sum[CNT_W] ? CNT_MAX : bytes_sum[CNT_W-1:0];
  assign cnt_dec   = (live_count == '0) ? '0 : live_count - 1'b1;
  assign bytes_dec = (live_bytes > rel) ? live_bytes - rel : '0;

  ath_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (state == S_PROBE),
    .raddr (rd_idx),
    .rdata (rd_key)
  );

  ath_ram #(.WIDTH(SIZE_W), .DEPTH(TABLE_DEPTH)) u_bytes_ram (
    .clk   (clk),
    .we    (bytes_we),
    .waddr (slot),
    .wdata (size),
    .re    (state == S_PROBE),
    .raddr (rd_idx),
    .rdata (rd_bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      en         <= 1'b0;
      clr_idx    <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
      done       <= 1'b0;
      live_count <= '0;
      live_bytes <= '0;
      max_count  <= '0;
      max_bytes  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        en <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op   <= request.operation;
            key  <= req_key;
            size <= request.alloc_size;
            hit  <= 1'b0;
            if (ignore) begin
              done                     <= 1'b1;
              result.status            <= ST_IGNORED;
              result.slot_index        <= '0;
              result.released_size     <= '0;
              result.outstanding_count <= live_count;
              result.bytes_in_use      <= live_bytes;
              result.peak_count        <= max_count;
              result.peak_bytes        <= max_bytes;
            end else begin
              h     <= '0;
              hcnt  <= '0;
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          h    <= h_next;
          hcnt <= hcnt + 1'b1;
          if (hcnt == 2'd3) begin
            pend    <= 1'b0;
            checked <= '0;
            if (DEPTH_P2) begin
              rd_idx <= h_next[AW-1:0];
              state  <= S_PROBE;
            end else begin
              q     <= h_next;
              r     <= '0;
              mcnt  <= '0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          q    <= q_next;
          r    <= r_next;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 3'd7) begin
            rd_idx <= r_next[AW-1:0];
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_idx   <= rd_idx_next;
          pend     <= 1'b1;
          pend_idx <= rd_idx;
          if (pend) begin
            checked <= checked + 1'b1;
            if (match) begin
              hit   <= 1'b1;
              slot  <= pend_idx;
              rel   <= rd_bytes;
              state <= S_FINISH;
            end else if (checked == CW'(TABLE_DEPTH - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          done                 <= 1'b1;
          result.slot_index    <= hit ? SLOT_W'(slot) : '0;
          result.released_size <= (hit && op == OP_RELEASE) ? rel : '0;
          if (op == OP_RECORD) begin
            live_count               <= cnt_inc;
            live_bytes               <= bytes_inc;
            max_count                <= (cnt_inc > max_count) ? cnt_inc : max_count;
            max_bytes                <= (bytes_inc > max_bytes) ? bytes_inc : max_bytes;
            result.status            <= hit ? ST_OK : ST_FULL;
            result.outstanding_count <= cnt_inc;
            result.bytes_in_use      <= bytes_inc;
            result.peak_count        <= (cnt_inc > max_count) ? cnt_inc : max_count;
            result.peak_bytes        <= (bytes_inc > max_bytes) ? bytes_inc : max_bytes;
          end else begin
            result.peak_count <= max_count;
            result.peak_bytes <= max_bytes;
            if (hit) begin
              live_count               <= cnt_dec;
              live_bytes               <= bytes_dec;
              result.status            <= ST_OK;
              result.outstanding_count <= cnt_dec;
              result.bytes_in_use      <= bytes_dec;
            end else begin
              result.status            <= ST_NOT_FOUND;
              result.outstanding_count <= live_count;
              result.bytes_in_use      <= live_bytes;
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_peak_count: assert property (@(posedge clk) disable iff (rst)
    done |-> result.peak_count >= result.outstanding_count)
    else $error("peak count below outstanding count");

  a_peak_bytes: assert property (@(posedge clk) disable iff (rst)
    done |-> result.peak_bytes >= result.bytes_in_use)
    else $error("peak bytes below bytes in use");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.slot_index == '0 && result.released_size == '0)
    else $error("slot or size reported on a failed item");

  a_no_write_in_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> !key_we && !bytes_we)
    else $error("table written during probing");

endmodule
